// ===== design/moving_average_jump_reset_defines.svh =====
// ----------------------------------------------------------------------------
// moving_average_jump_reset assertion macros
// Shared concurrent assertion shorthands for the moving average design.
// ----------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_JUMP_RESET_DEFINES_SVH
`define MOVING_AVERAGE_JUMP_RESET_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define MAJ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define MAJ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/maj_pkg.sv =====
// ----------------------------------------------------------------------------
// maj_pkg
// Shared widths, defaults and types of the moving average with jump reset.
// ----------------------------------------------------------------------------
package maj_pkg;

    // Sample width, unsigned Q2.14
    localparam int DATA_W = 16;

    // Default window length
    localparam int WINDOW_LENGTH_DEF = 20;

    // Jump threshold after reset, about 0.02 in Q2.14
    localparam logic [DATA_W-1:0] THRESH_RST = 16'd328;

    // Per-beat side info that travels alongside the running sum
    typedef struct packed {
        logic              restart;
        logic [DATA_W-1:0] sample;
    } t_item;

endpackage

// ===== design/maj_cell.sv =====
// ----------------------------------------------------------------------------
// maj_cell
// One window entry: shifts in its neighbor's value, or loads the fill value.
// ----------------------------------------------------------------------------
module maj_cell
    import maj_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,       // a beat is accepted
    input  logic              i_restart,  // refill the whole window
    input  logic [DATA_W-1:0] i_fill,     // refill value (the new sample)
    input  logic [DATA_W-1:0] i_prev,     // entry of the upstream neighbor
    output logic [DATA_W-1:0] o_entry
);

    logic [DATA_W-1:0] r_entry;
    logic [DATA_W-1:0] n_entry;

    // next entry: refill wins over shift
    always_comb begin
        n_entry = r_entry;
        if (i_en) begin
            n_entry = i_restart ? i_fill : i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

// ===== design/maj_mean.sv =====
// ----------------------------------------------------------------------------
// maj_mean
// Two-stage divide of the running sum by the window length, output register.
// ----------------------------------------------------------------------------
module maj_mean
    import maj_pkg::*;
#(
    parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    output logic                                     o_ready,
    input  logic [DATA_W+$clog2(WINDOW_LENGTH)-1:0]  i_sum,
    input  t_item                                    i_item,
    output logic                                     o_valid,
    input  logic                                     i_ready,
    output logic [DATA_W-1:0]                        o_value,
    output logic                                     o_restart
);

    localparam int SUM_W   = DATA_W + $clog2(WINDOW_LENGTH);
    localparam int LOG_N   = $clog2(WINDOW_LENGTH);
    localparam int SHIFT   = SUM_W + LOG_N;
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    // ceil(2^SHIFT / N): exact floor division for any sum below 2^SUM_W
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    logic              r_p2_valid;
    logic [PROD_W-1:0] r_p2_prod;
    t_item             r_p2_item;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_value;
    logic              r_out_restart;

    logic              w_out_ready;
    logic              w_p2_ready;
    logic [DATA_W-1:0] w_quot;

    // each stage takes a beat when empty or when it drains this cycle
    assign w_out_ready = !r_out_valid || i_ready;
    assign w_p2_ready  = !r_p2_valid || w_out_ready;
    assign o_ready     = w_p2_ready;

    assign w_quot = r_p2_prod[SHIFT +: DATA_W];

    // reciprocal multiply stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_valid <= 1'b0;
        end else if (w_p2_ready) begin
            r_p2_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_p2_ready && i_valid) begin
            r_p2_prod <= PROD_W'(i_sum) * PROD_W'(RECIP);
            r_p2_item <= i_item;
        end
    end

    // output register: mean, or the sample itself after a refill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= r_p2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ready && r_p2_valid) begin
            r_out_value   <= r_p2_item.restart ? r_p2_item.sample : w_quot;
            r_out_restart <= r_p2_item.restart;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_value   = r_out_value;
    assign o_restart = r_out_restart;

endmodule

// ===== design/moving_average_jump_reset.sv =====
// ----------------------------------------------------------------------------
// moving_average_jump_reset
// Boxcar moving average over a row of entry cells, refilled on a step.
// ----------------------------------------------------------------------------
// One sample beat is taken every clock cycle until a result beat that is not
// taken stalls the pipeline stage by stage and all stages fill. Each gives one
// result beat via window update, reciprocal multiply and output register. The
// window is a row of WINDOW_LENGTH cells that shift by one per beat and all
// load the sample on a restart, with a running sum beside them; the restart
// decision compares the sum against N*(x+T+1) and N*(x-T), so the window
// state is ready for the next sample in the same cycle. Entries clear to zero
// at reset with no clearing pass. The user is to write jump_threshold on the
// cfg channel only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "moving_average_jump_reset_defines.svh"

module moving_average_jump_reset
    import maj_pkg::*;
#(
    parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration write: jump_threshold
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [DATA_W-1:0] i_cfg_data,
    // sample input
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,   // [15:0] sample_value
    // result output
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,   // [15:0] average_value
    output logic [0:0]        m_axis_tuser    // [0] restarted
);

    localparam int SUM_W  = DATA_W + $clog2(WINDOW_LENGTH);
    localparam int NW     = $clog2(WINDOW_LENGTH + 1);
    localparam int PROD_W = DATA_W + 1 + NW;
    localparam logic [NW-1:0] N_C = NW'(WINDOW_LENGTH);

    logic [DATA_W-1:0] r_thresh;
    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  n_sum;
    logic              r_p1_valid;
    logic [SUM_W-1:0]  r_p1_sum;
    t_item             r_p1_item;

    logic [DATA_W-1:0] w_entry [WINDOW_LENGTH];
    logic              w_accept;
    logic              w_mean_ready;
    logic              w_jump;
    logic              w_above;
    logic [SUM_W-1:0]  w_sum_upd;
    logic [SUM_W-1:0]  w_sum_fill;
    logic [PROD_W-1:0] w_hi_lim;
    logic [PROD_W-1:0] w_lo_lim;
    logic [PROD_W-1:0] w_sum_ext;
    t_item             w_item;

    // configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RST;
        end else if (i_cfg_valid) begin
            r_thresh <= i_cfg_data;
        end
    end

    // window update stage takes a beat when empty or draining
    assign s_axis_tready = !r_p1_valid || w_mean_ready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // running sum: drop oldest cell, add new sample
    assign w_sum_upd = r_sum - SUM_W'(w_entry[WINDOW_LENGTH-1]) + SUM_W'(s_axis_tdata);
    assign w_sum_ext = PROD_W'(w_sum_upd);

    // mean > x+T  <=>  sum >= N*(x+T+1);  mean < x-T  <=>  sum < N*(x-T)
    assign w_above  = s_axis_tdata > r_thresh;
    assign w_hi_lim = (PROD_W'(s_axis_tdata) + PROD_W'(r_thresh) + PROD_W'(1)) * PROD_W'(N_C);
    assign w_lo_lim = PROD_W'(s_axis_tdata - r_thresh) * PROD_W'(N_C);
    assign w_jump   = (w_sum_ext >= w_hi_lim) || (w_above && (w_sum_ext < w_lo_lim));

    assign w_sum_fill = SUM_W'(PROD_W'(s_axis_tdata) * PROD_W'(N_C));

    always_comb begin
        n_sum = r_sum;
        if (w_accept) begin
            n_sum = w_jump ? w_sum_fill : w_sum_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else begin
            r_sum <= n_sum;
        end
    end

    // row of window cells
    for (genvar k = 0; k < WINDOW_LENGTH; k++) begin : g_cell
        maj_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (w_accept),
            .i_restart (w_jump),
            .i_fill    (s_axis_tdata),
            .i_prev    ((k == 0) ? s_axis_tdata : w_entry[(k == 0) ? 0 : k-1]),
            .o_entry   (w_entry[k])
        );
    end

    // hand the updated sum on to the divide stages
    assign w_item.restart = w_jump;
    assign w_item.sample  = s_axis_tdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_p1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_p1_sum  <= w_sum_upd;
            r_p1_item <= w_item;
        end
    end

    maj_mean #(
        .WINDOW_LENGTH (WINDOW_LENGTH)
    ) u_mean (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_p1_valid),
        .o_ready   (w_mean_ready),
        .i_sum     (r_p1_sum),
        .i_item    (r_p1_item),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_value   (m_axis_tdata),
        .o_restart (m_axis_tuser[0])
    );

    // input stalls only when every stage up to the output holds a beat
    `MAJ_ASSERT_NOW(a_stall_full, !s_axis_tready, r_p1_valid && m_axis_tvalid,
        "input stalled while pipeline has a hole")

    // after a refill the first and last cells agree
    `MAJ_ASSERT_NEXT(a_refill_flat, w_accept && w_jump,
        w_entry[0] == w_entry[WINDOW_LENGTH-1], "window not uniform after refill")

    // running sum never exceeds N full-scale samples
    `MAJ_ASSERT_NOW(a_sum_bound, 1'b1,
        PROD_W'(r_sum) <= PROD_W'({DATA_W{1'b1}}) * PROD_W'(N_C),
        "running sum out of range")

endmodule

// ===== tb/sv/moving_average_jump_reset_checker.sv =====
// ----------------------------------------------------------------------------
// moving_average_jump_reset checker
// Watches the cfg, sample and result channels, keeps its own copy of the
// averaging window and compares every result beat with the predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module moving_average_jump_reset_checker
    import maj_pkg::*;
#(
    parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [DATA_W-1:0] i_cfg_data,
    input  logic              i_s_tvalid,
    input  logic              i_s_tready,
    input  logic [DATA_W-1:0] i_s_tdata,   // [15:0] sample_value
    input  logic              i_m_tvalid,
    input  logic              i_m_tready,
    input  logic [DATA_W-1:0] i_m_tdata,   // [15:0] average_value
    input  logic [0:0]        i_m_tuser,   // [0] restarted
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        logic [DATA_W-1:0] average;
        logic              restarted;
    } t_avg_result;

    // Shadow window state
    logic [DATA_W-1:0] hist_cells [WINDOW_LENGTH];
    logic [21:0]       hist_sum;
    int unsigned       hist_pos;
    logic [DATA_W-1:0] jump_thresh;

    // Predicted results not yet seen on the output
    t_avg_result avg_q [$];

    initial o_fail_count = 0;
    initial o_pending = 0;

    // Add one sample to the window and work out the result beat
    function automatic t_avg_result predict_average(input logic [DATA_W-1:0] x);
        logic [21:0] mean;
        logic [21:0] dev;
        t_avg_result r;
        hist_sum = hist_sum - hist_cells[hist_pos] + x;
        hist_cells[hist_pos] = x;
        hist_pos = (hist_pos == WINDOW_LENGTH - 1) ? 0 : hist_pos + 1;
        mean = 22'(hist_sum / WINDOW_LENGTH);
        dev = (mean > x) ? (mean - x) : (x - mean);
        if (dev > jump_thresh) begin
            // step detected: refill every entry with the sample
            for (int i = 0; i < WINDOW_LENGTH; i++)
                hist_cells[i] = x;
            hist_sum = 22'(x * WINDOW_LENGTH);
            r.average = x;
            r.restarted = 1'b1;
        end else begin
            r.average = mean[DATA_W-1:0];
            r.restarted = 1'b0;
        end
        return r;
    endfunction

    // Track beats on all channels
    always @(posedge i_clk) begin
        t_avg_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW_LENGTH; i++)
                hist_cells[i] = '0;
            hist_sum = '0;
            hist_pos = 0;
            jump_thresh = THRESH_RST;
            avg_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                jump_thresh = i_cfg_data;
            // compare before queuing, so a result beat that arrives with its own sample is caught
            if (i_m_tvalid && i_m_tready) begin
                if (avg_q.size() == 0) begin
                    $error("unexpected result beat: average_value %0d restarted %0d",
                           i_m_tdata, i_m_tuser[0]);
                    o_fail_count++;
                end else begin
                    want = avg_q.pop_front();
                    if (i_m_tdata !== want.average) begin
                        $error("average_value: expected %0d, got %0d",
                               want.average, i_m_tdata);
                        o_fail_count++;
                    end
                    if (i_m_tuser[0] !== want.restarted) begin
                        $error("restarted: expected %0d, got %0d",
                               want.restarted, i_m_tuser[0]);
                        o_fail_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                avg_q.push_back(predict_average(i_s_tdata));
        end
        o_pending <= avg_q.size();
    end

endmodule

// ===== tb/sv/tb_moving_average_jump_reset.sv =====
// ----------------------------------------------------------------------------
// tb_moving_average_jump_reset
// Drives sample and threshold beats into the moving average with random
// stalls on both sides; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_moving_average_jump_reset
    import maj_pkg::*;
();

    logic              i_clk;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_valid   = 1'b0;
    logic              o_cfg_ready;
    logic [DATA_W-1:0] i_cfg_data    = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;
    logic [0:0]        m_axis_tuser;

    int fail_count;
    int pending;

    // Stall rates in percent
    int tx_idle_pct = 13;
    int rx_idle_pct = 68;

    // Slowly moving signal level for the random samples
    int level_base = 16384;

    moving_average_jump_reset #(
        .WINDOW_LENGTH(WINDOW_LENGTH_DEF)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    moving_average_jump_reset_checker #(
        .WINDOW_LENGTH(WINDOW_LENGTH_DEF)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .i_m_tdata   (m_axis_tdata),
        .i_m_tuser   (m_axis_tuser),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // 8 ns clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Result side back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // One sample beat, with random idle cycles ahead of it
    task automatic send_sample(input logic [DATA_W-1:0] value);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Hold off the sender until every result is out and the pipe is empty
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [DATA_W-1:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int sel;
        int span;
        int level;
        logic [DATA_W-1:0] thresh;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset threshold, restarts both ways, exact threshold
        send_sample(16'd0);
        send_sample(16'd65535);
        send_sample(16'd0);
        send_sample(16'd10000);
        send_sample(16'd10345);     // deviation equals threshold, upward
        send_sample(16'd30000);
        send_sample(16'd30346);     // one above threshold
        send_sample(16'd30000);     // deviation equals threshold, downward
        send_sample(16'd65535);
        send_sample(16'd65535);

        // Zero threshold: any deviation restarts
        write_threshold(16'd0);
        send_sample(16'd1000);
        send_sample(16'd1000);
        send_sample(16'd1001);
        send_sample(16'd1001);

        // Full-scale threshold: never restarts
        write_threshold(16'hFFFF);
        send_sample(16'd0);
        send_sample(16'd65535);
        send_sample(16'd0);
        send_sample(16'h5555);
        send_sample(16'hAAAA);
        send_sample(16'hFFFF);

        // Random: three stall profiles, three threshold settings each
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 13; rx_idle_pct = 68; end
                1: begin tx_idle_pct = 68; rx_idle_pct = 13; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            for (int seg = 0; seg < 3; seg++) begin
                case ($urandom_range(5))
                    0: thresh = 16'd0;
                    1: thresh = 16'hFFFF;
                    2: thresh = THRESH_RST;
                    3: thresh = 16'($urandom_range(2000));
                    4: thresh = 16'($urandom_range(200));
                    default: thresh = 16'($urandom_range(65535));
                endcase
                write_threshold(thresh);
                for (int n = 0; n < 55; n++) begin
                    sel = $urandom_range(99);
                    if (sel < 8) begin
                        // step to a new level, sometimes to a rail
                        if ($urandom_range(3) == 0)
                            level_base = $urandom_range(1) ? 65535 : 0;
                        else
                            level_base = $urandom_range(65535);
                        level = level_base;
                    end else if (sel < 20) begin
                        level = $urandom_range(65535);
                    end else begin
                        // noisy sample around the current level
                        span = $urandom_range(1) ? 400 : 3000;
                        level = level_base + int'($urandom_range(2 * span)) - span;
                        if (level < 0)
                            level = 0;
                        else if (level > 65535)
                            level = 65535;
                    end
                    send_sample(level[DATA_W-1:0]);
                end
            end
        end

        drain();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/maj_pkg.sv
design/maj_cell.sv
design/maj_mean.sv
design/moving_average_jump_reset.sv
tb/sv/moving_average_jump_reset_checker.sv
tb/sv/tb_moving_average_jump_reset.sv
